// File: hw/rtl/chgs_pkg.sv
// Package: payload types and constants for the convex hull block.
`timescale 1ns / 1ps
`default_nettype none
package chgs_pkg;
  localparam int unsigned NPTS = 32;
  localparam int unsigned IW   = $clog2(NPTS);
  localparam int unsigned CW   = $clog2(NPTS + 1);
  localparam int unsigned SW   = $clog2(NPTS + 2);

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               point_valid;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [5:0] hull_index;
    logic              last_result;
    logic              overflow;
  } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/chgs_mul.sv
// Shared 34x34 signed multiply-subtract: r = a*b - c*d, one product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module chgs_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [33:0] a_i,
  input  wire logic signed [33:0] b_i,
  input  wire logic signed [33:0] c_i,
  input  wire logic signed [33:0] d_i,
  output logic                    done_o,
  output logic signed [69:0]      res_o
);
  logic [1:0] ph_q, ph_d;
  logic signed [33:0] a_q, b_q, c_q, d_q;
  logic signed [67:0] p_q;
  logic signed [69:0] r_q;
  logic signed [33:0] m1, m2;

  assign m1 = (ph_q == 2'd1) ? a_q : c_q;
  assign m2 = (ph_q == 2'd1) ? b_q : d_q;

  always_comb begin
    ph_d = ph_q;
    if (start_i) ph_d = 2'd1;
    else if (ph_q == 2'd1) ph_d = 2'd2;
    else if (ph_q == 2'd2) ph_d = 2'd3;
    else if (ph_q == 2'd3) ph_d = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= 2'd0;
    else ph_q <= ph_d;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i; b_q <= b_i; c_q <= c_i; d_q <= d_i;
    end
    if (ph_q == 2'd1 || ph_q == 2'd2) p_q <= m1 * m2;
    if (ph_q == 2'd2) r_q <= 70'(p_q);
    if (ph_q == 2'd3) r_q <= r_q - 70'(p_q);
  end

  assign done_o = (ph_q == 2'd0) && !start_i;
  assign res_o  = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/convex_hull_graham_scan.sv
// Top level: point store, insertion sort and Graham scan sequencer.
// After the last point (N points held): a start search over the N points; an insertion sort
//   whose compare steps use the shared multiplier when the sign test cannot decide,
//   N*(N-1)/2 steps at worst; a scan with a cross-product test per point; then NPTS
//   (NPTS+1 with close_loop) results.
// Throughput: one set at a time; points load one per cycle; input stalls until the row ends.
// Reset: asynchronous active low; clears control, count, overflow flag and close_loop.
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_graham_scan (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire chgs_pkg::point_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output chgs_pkg::result_t     out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i
);
  import chgs_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0, S_MIN = 4'd1, S_SI = 4'd2, S_SC = 4'd3,
    S_SW = 4'd4, S_HI = 4'd5, S_HR = 4'd6, S_HW = 4'd7, S_OUT = 4'd8, S_SR = 4'd9,
    S_HR2 = 4'd10, S_CL = 4'd11;

  logic [3:0] st_q, st_d;
  logic signed [15:0] xs [NPTS];
  logic signed [15:0] ys [NPTS];
  logic               vs [NPTS];
  logic [IW-1:0]      so [NPTS];
  logic [IW-1:0]      hs [NPTS];

  logic [CW-1:0] cnt_q;
  logic          ovf_q, cl_q, cl_use_q;
  logic [CW-1:0] i_q, k_q;
  logic [IW-1:0] s_q, v_q, j_q;
  logic          found_q;
  logic [SW-1:0] top_q;
  logic [CW:0]   o_q;
  logic          swap_go, gt_q, hr_skip;

  logic in_acc, out_acc;
  assign in_stall_o = (st_q != S_LOAD);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // multiplier operands
  logic mstart, mdone;
  logic signed [33:0] ma, mb, mc, md;
  logic signed [69:0] mres;
  chgs_mul u_mul (.clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .c_i(mc),
                  .d_i(md), .done_o(mdone), .res_o(mres));

  // sort compare: cos(v) > cos(so[k-1])
  logic [IW-1:0] b_idx;
  logic signed [16:0] dxa, dya, dxb, dyb;
  logic [33:0] qa, qb, ra, rb;
  logic sa_p, sa_z, sb_p, sb_z, cg_fast, cg_dec;
  assign b_idx = so[IW'(k_q - 1'b1)];
  assign dxa = 17'(xs[v_q]) - 17'(xs[s_q]);
  assign dya = 17'(ys[v_q]) - 17'(ys[s_q]);
  assign dxb = 17'(xs[b_idx]) - 17'(xs[s_q]);
  assign dyb = 17'(ys[b_idx]) - 17'(ys[s_q]);
  assign qa = 34'(dxa * dxa);
  assign qb = 34'(dxb * dxb);
  assign ra = qa + 34'(dya * dya);
  assign rb = qb + 34'(dyb * dyb);
  assign sa_z = (dxa == 0); assign sa_p = !dxa[16] && !sa_z;
  assign sb_z = (dxb == 0); assign sb_p = !dxb[16] && !sb_z;
  // decided without products when signs differ or both zero
  assign cg_fast = (sa_p != sb_p) || (sa_z != sb_z) || sa_z;
  assign cg_dec = (sa_p && !sb_p) || (sa_z && dxb[16]);

  // stack points
  logic [IW-1:0] t1, t2, j_now;
  logic signed [16:0] ex1, ey1, ex0, ey0;
  assign j_now = so[i_q[IW-1:0]];
  assign t1 = hs[top_q[IW-1:0]];
  assign t2 = hs[IW'(top_q - 1'b1)];
  assign ex1 = 17'(xs[t1]) - 17'(xs[t2]);
  assign ey1 = 17'(ys[t1]) - 17'(ys[t2]);
  assign ex0 = 17'(xs[j_q]) - 17'(xs[t2]);
  assign ey0 = 17'(ys[j_q]) - 17'(ys[t2]);
  // start, masked point or duplicate of the top entry
  assign hr_skip = (j_q == s_q) || !vs[j_q] ||
                   (xs[j_q] == xs[t1] && ys[j_q] == ys[t1]);

  always_comb begin
    ma = 34'(ex1); mb = 34'(ey0); mc = 34'(ey1); md = 34'(ex0);
    if (st_q == S_SC) begin
      ma = qa; mb = rb; mc = qb; md = ra;
    end
  end

  logic [CW:0] row_len;
  assign row_len = (CW+1)'(NPTS) + (CW+1)'(cl_use_q);

  always_comb begin
    st_d = st_q;
    mstart = 1'b0;
    case (st_q)
      S_LOAD:  if (in_acc && in_data_i.last_point) st_d = S_MIN;
      S_MIN:   if (i_q == cnt_q) st_d = S_SI;
      S_SI:    st_d = (i_q == cnt_q) ? S_HI : S_SC;
      S_SC:    if (k_q == 0 || cg_fast) st_d = S_SW;
               else begin mstart = 1'b1; st_d = S_SR; end
      S_SR:    if (mdone) st_d = S_SW;
      S_SW:    st_d = swap_go ? S_SC : S_SI;
      S_HI:    st_d = (i_q == cnt_q) ? S_CL : S_HR;
      S_HR:    st_d = (hr_skip || top_q < SW'(2)) ? S_HI : S_HR2;
      S_HR2:   begin mstart = 1'b1; st_d = S_HW; end
      S_HW:    if (mdone) st_d = (!mres[69] || top_q <= SW'(1)) ? S_HI : S_HR2;
      S_CL:    st_d = S_OUT;
      S_OUT:   if (out_acc && o_q == row_len - 1'b1) st_d = S_LOAD;
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; cnt_q <= '0; ovf_q <= 1'b0; cl_q <= 1'b0; cl_use_q <= 1'b0;
      i_q <= '0; k_q <= '0; s_q <= '0; v_q <= '0; j_q <= '0; found_q <= 1'b0;
      top_q <= '0; o_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) cl_q <= cfg_wdata_i;
      case (st_q)
        S_LOAD: if (in_acc) begin
          if (cnt_q == CW'(NPTS)) ovf_q <= 1'b1;
          else cnt_q <= cnt_q + 1'b1;
          if (in_data_i.last_point) begin
            i_q <= '0; s_q <= '0; found_q <= 1'b0; cl_use_q <= cl_q;
          end
        end
        S_MIN: if (i_q != cnt_q) begin
          if (vs[i_q[IW-1:0]] && (!found_q || ys[i_q[IW-1:0]] < ys[s_q])) begin
            s_q <= i_q[IW-1:0]; found_q <= 1'b1;
          end
          i_q <= i_q + 1'b1;
        end else i_q <= '0;
        S_SI: begin
          v_q <= i_q[IW-1:0]; k_q <= i_q;
          if (i_q == cnt_q) begin i_q <= '0; top_q <= '0; end
        end
        S_SW: begin
          if (swap_go) k_q <= k_q - 1'b1;
          else i_q <= i_q + 1'b1;
        end
        S_HI: if (i_q != cnt_q) j_q <= j_now;
        S_HR: begin
          i_q <= i_q + 1'b1;
          if (!hr_skip && top_q < SW'(2)) top_q <= top_q + 1'b1;
        end
        S_HW: if (mdone) begin
          if (!mres[69]) top_q <= top_q + 1'b1;
          else if (top_q > SW'(1)) top_q <= top_q - 1'b1;
        end
        S_CL: begin
          if (cl_use_q) top_q <= top_q + 1'b1;
          o_q <= '0;
        end
        S_OUT: if (out_acc) begin
          o_q <= o_q + 1'b1;
          if (o_q == row_len - 1'b1) begin cnt_q <= '0; ovf_q <= 1'b0; end
        end
        default: ;
      endcase
    end
  end

  // sort decision latched from fast path or multiplier
  always_comb begin
    swap_go = (k_q != 0) && gt_q;
  end
  always_ff @(posedge clk_i) begin
    if (st_q == S_SC) gt_q <= cg_fast ? cg_dec : 1'b0;
    if (st_q == S_SR && mdone) gt_q <= sa_p ? (mres > 0) : (mres < 0);
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_q != CW'(NPTS)) begin
      xs[cnt_q[IW-1:0]] <= in_data_i.point_x;
      ys[cnt_q[IW-1:0]] <= in_data_i.point_y;
      vs[cnt_q[IW-1:0]] <= in_data_i.point_valid;
    end
    if (st_q == S_SW) begin
      if (swap_go) so[k_q[IW-1:0]] <= b_idx;
      else so[k_q[IW-1:0]] <= v_q;
    end
    if (st_q == S_SI && i_q == cnt_q) hs[0] <= s_q;
    if (st_q == S_HR && !hr_skip && top_q < SW'(2))
      hs[IW'(top_q + 1'b1)] <= j_q;
    if (st_q == S_HW && mdone) begin
      if (!mres[69]) hs[IW'(top_q + 1'b1)] <= j_q;
      else if (top_q <= SW'(1)) hs[top_q[IW-1:0]] <= j_q;
    end
  end

  // closing entry is the start index, not kept in the stack memory
  assign out_valid_o = (st_q == S_OUT);
  always_comb begin
    if (o_q > (CW+1)'(top_q)) out_data_o.hull_index = 6'h3f;
    else if (cl_use_q && o_q == (CW+1)'(top_q)) out_data_o.hull_index = 6'(s_q);
    else out_data_o.hull_index = 6'(hs[IW'(o_q)]);
    out_data_o.last_result = (o_q == row_len - 1'b1);
    out_data_o.overflow = ovf_q;
  end

`ifndef SYNTHESIS
  a_nocnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NPTS)) else $error("count beyond NPTS");
  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= SW'(NPTS + 1)) else $error("stack overrun");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during output");
`endif
endmodule
`default_nettype wire

// File: sim/convex_hull_graham_scan_tb.sv
// Testbench for the convex hull block: directed and random point sets against a hull predictor.
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_graham_scan_tb;
  import chgs_pkg::*;

  localparam int MAX_CYCLES = 3000000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  point_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;
  logic    cfg_we_i = 1'b0;
  logic    cfg_wdata_i = 1'b0;

  convex_hull_graham_scan dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  longint  px[NPTS];
  longint  py[NPTS];
  bit      pv[NPTS];
  int      npts_held;
  bit      dropped;
  bit      loop_mode;
  result_t hull_q[$];

  int  errors;
  int  cycle_cnt;
  bit  idle_on = 1'b1;
  bit  flood = 1'b0;  // small clustered coordinates

  task automatic report(input string what);
    errors++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // a*b vs c*d on unsigned 64-bit operands, exact
  function automatic int cmp_prod(input bit [63:0] a, b, c, d);
    bit [127:0] l, r;
    l = 128'(a) * 128'(b);
    r = 128'(c) * 128'(d);
    return (l > r) ? 1 : (l < r) ? -1 : 0;
  endfunction

  function automatic bit cos_gt(input int a, input int b, input int s);
    longint dxa, dya, dxb, dyb;
    int sa, sb, c;
    dxa = px[a] - px[s]; dya = py[a] - py[s];
    dxb = px[b] - px[s]; dyb = py[b] - py[s];
    sa = (dxa > 0) - (dxa < 0);
    sb = (dxb > 0) - (dxb < 0);
    if (sa != sb) return sa > sb;
    if (sa == 0) return 1'b0;
    c = cmp_prod(dxa * dxa, dxb * dxb + dyb * dyb, dxb * dxb, dxa * dxa + dya * dya);
    return sa > 0 ? c > 0 : c < 0;
  endfunction

  task automatic predict_hull(input point_t p);
    int order[NPTS];
    int stk[NPTS + 1];
    int s, top, j, k, v, row, n;
    bit found;
    longint x0, y0, x1, y1, x2, y2, t;
    result_t r;
    if (npts_held < NPTS) begin
      px[npts_held] = p.point_x;
      py[npts_held] = p.point_y;
      pv[npts_held] = p.point_valid;
      npts_held++;
    end else begin
      dropped = 1'b1;
    end
    if (!p.last_point) return;
    n = npts_held;
    s = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++)
      if (pv[i] && (!found || py[i] < py[s])) begin
        s = i;
        found = 1'b1;
      end
    for (int i = 0; i < n; i++) begin
      v = i;
      k = i;
      while (k > 0 && cos_gt(v, order[k-1], s)) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = v;
    end
    stk[0] = s;
    top = 0;
    for (int i = 0; i < n; i++) begin
      j = order[i];
      if (j == s || !pv[j]) continue;
      x0 = px[j]; y0 = py[j];
      x1 = px[stk[top]]; y1 = py[stk[top]];
      if (x0 == x1 && y0 == y1) continue;
      if (top < 2) begin
        top++;
        stk[top] = j;
        continue;
      end
      x2 = px[stk[top-1]]; y2 = py[stk[top-1]];
      forever begin
        t = (x1 - x2) * (y0 - y2) - (y1 - y2) * (x0 - x2);
        if (t >= 0) begin
          top++;
          stk[top] = j;
          break;
        end
        if (top <= 1) begin
          stk[top] = j;
          break;
        end
        top--;
        x1 = px[stk[top]]; y1 = py[stk[top]];
        x2 = px[stk[top-1]]; y2 = py[stk[top-1]];
      end
    end
    if (loop_mode) begin
      top++;
      stk[top] = s;
    end
    row = NPTS + loop_mode;
    for (int i = 0; i < row; i++) begin
      r.hull_index = (i <= top) ? 6'(stk[i]) : 6'h3f;
      r.last_result = (i + 1 == row);
      r.overflow = dropped;
      hull_q.push_back(r);
    end
    npts_held = 0;
    dropped = 1'b0;
  endtask

  // valid stays up after acceptance; the next request, an idle gap or drain replaces it
  task automatic send_point(input point_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    predict_hull(p);
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (hull_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_loop(input bit val);
    drain();
    loop_mode = val;
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic point_t rand_point(input bit last);
    point_t p;
    if (flood) begin
      p.point_x = 16'($signed($urandom_range(0, 8)) - 4);
      p.point_y = 16'($signed($urandom_range(0, 8)) - 4);
    end else begin
      p.point_x = 16'($urandom);
      p.point_y = 16'($urandom);
    end
    p.point_valid = ($urandom_range(0, 7) != 0);
    p.last_point = last;
    return p;
  endfunction

  task automatic send_set(input int cnt);
    for (int i = 0; i < cnt; i++) send_point(rand_point(i == cnt - 1));
  endtask

  function automatic point_t mk(input int x, y, input bit v, last);
    point_t p;
    p.point_x = 16'(x); p.point_y = 16'(y);
    p.point_valid = v; p.last_point = last;
    return p;
  endfunction

  task automatic test_square_extremes();
    send_point(mk(-32768, -32768, 1, 0));
    send_point(mk(32767, -32768, 1, 0));
    send_point(mk(32767, 32767, 1, 0));
    send_point(mk(-32768, 32767, 1, 0));
    send_point(mk(0, 0, 1, 0));
    send_point(mk(32767, 32767, 1, 0));   // duplicate of a corner
    send_point(mk(5, 5, 0, 1));           // masked point
  endtask

  task automatic test_no_valid();
    send_point(mk(1, 2, 0, 0));
    send_point(mk(-3, -4, 0, 1));
  endtask

  task automatic test_collinear_and_single();
    send_point(mk(0, 0, 1, 0));
    send_point(mk(1, 1, 1, 0));
    send_point(mk(2, 2, 1, 0));
    send_point(mk(3, 3, 1, 0));
    send_point(mk(-1, 0, 1, 1));
    send_point(mk(7, -7, 1, 1));          // one-point set
  endtask

  task automatic test_overflow();
    send_set(NPTS + 3);
  endtask

  task automatic test_random_sets();
    int total;
    total = 0;
    while (total < 300) begin
      int cnt;
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NPTS + 2) : $urandom_range(1, 8);
      flood = $urandom_range(0, 2) == 0;
      send_set(cnt);
      total += cnt;
      if ($urandom_range(0, 15) == 0) set_loop(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 20) == 0) drain();  // sender holds off until all results are in
    end
    flood = 1'b0;
  endtask

  // result stall pattern
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hull_q.size() == 0) begin
        report("result with none expected");
      end else begin
        result_t e;
        e = hull_q.pop_front();
        if (out_data_o.hull_index !== e.hull_index)
          report($sformatf("hull_index %0d, want %0d", out_data_o.hull_index, e.hull_index));
        if (out_data_o.last_result !== e.last_result)
          report($sformatf("last_result %b, want %b", out_data_o.last_result, e.last_result));
        if (out_data_o.overflow !== e.overflow)
          report($sformatf("overflow %b, want %b", out_data_o.overflow, e.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    errors = 0;
    npts_held = 0;
    dropped = 1'b0;
    loop_mode = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_square_extremes();
    test_no_valid();
    set_loop(1'b1);
    test_collinear_and_single();
    test_no_valid();
    test_overflow();
    set_loop(1'b0);
    test_overflow();
    test_random_sets();
    drain();
    idle_on = 1'b0;
    set_loop(1'b1);
    send_set(6);
    send_set(NPTS);
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
